FILE: design/esi_pkg.sv
`timescale 1ns / 1ps

package esi_pkg;

  localparam int GAP_W      = 32;
  localparam int STAMP_W    = 64;
  localparam int SEEN_W     = 32;
  localparam int MEAN_OUT_W = 48;
  localparam int SUM_W      = 63;
  localparam int SUM_FRAC   = 8;

  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIVW,
    S_MEAN,
    S_ERR,
    S_MUL,
    S_MULW,
    S_SUM,
    S_DONE
  } esi_state_t;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } esi_op_t;

  typedef struct packed {
    logic    start;
    esi_op_t op;
  } esi_unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } esi_unit_sts_t;

endpackage

FILE: design/esi_serial_unit.sv
`timescale 1ns / 1ps

module esi_serial_unit import esi_pkg::*; #(
  parameter int MEAN_W = 48,
  parameter int CNT_W  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  esi_unit_ctl_t         ctl,
  input  logic [MEAN_W-1:0]     opa,
  input  logic [MEAN_W-1:0]     opb,
  input  logic [CNT_W-1:0]      divisor,
  output esi_unit_sts_t         sts,
  output logic [MEAN_W-1:0]     quot,
  output logic [2*MEAN_W-1:0]   prod
);

  localparam int AW     = ((MEAN_W > CNT_W) ? MEAN_W : CNT_W) + 1;
  localparam int STEP_W = $clog2(MEAN_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MEAN_W - 1);

  logic              busy;
  logic              done;
  esi_op_t           op;
  logic [STEP_W-1:0] step;
  logic [AW-1:0]     hi;
  logic [MEAN_W-1:0] lo;
  logic [MEAN_W-1:0] mcand;
  logic [CNT_W-1:0]  dvs;

  logic [AW-1:0] rem_sh;
  logic [AW-1:0] op_a;
  logic [AW-1:0] op_b;
  logic          cin;
  logic [AW:0]   res;

  // one adder: restoring divide (subtract) or shift-add multiply
  always_comb begin
    rem_sh = {hi[AW-2:0], lo[MEAN_W-1]};
    cin    = (op == OP_DIV);
    if (op == OP_DIV) begin
      op_a = rem_sh;
      op_b = ~AW'(dvs);
    end else begin
      op_a = hi;
      op_b = lo[0] ? AW'(mcand) : '0;
    end
    res = {1'b0, op_a} + {1'b0, op_b} + {{AW{1'b0}}, cin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_DIV;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        step <= LAST_STEP;
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hi    <= '0;
      lo    <= (ctl.op == OP_DIV) ? opa : opb;
      mcand <= opa;
      dvs   <= divisor;
    end else if (busy) begin
      if (op == OP_DIV) begin
        hi <= res[AW] ? res[AW-1:0] : rem_sh;
        lo <= {lo[MEAN_W-2:0], res[AW]};
      end else begin
        hi <= res[AW:1];
        lo <= {res[0], lo[MEAN_W-1:1]};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quot     = lo;
  assign prod     = {hi[MEAN_W-1:0], lo};

endmodule

FILE: design/event_interval_statistics_top.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_ready  func, now_us
// out      out_valid/ out_ready events_seen, shortest_gap, longest_gap, mean_gap,
//                               spread_sum, first_stamp, last_stamp
//
// Clear and the first two events after a clear do not use the serial unit.
// Later events run a bit-serial divide then a bit-serial multiply, both on the one
// shared adder of esi_serial_unit.
// in_ready is high only while idle; the next item is taken while a result waits on out.
// rst is synchronous and clears all statistics to zero.

module event_interval_statistics_top import esi_pkg::*; #(
  parameter int MEAN_FRAC_BITS = 16,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [STAMP_W-1:0]    now_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEEN_W-1:0]     events_seen,
  output logic [GAP_W-1:0]      shortest_gap,
  output logic [GAP_W-1:0]      longest_gap,
  output logic [MEAN_OUT_W-1:0] mean_gap,
  output logic [SUM_W-1:0]      spread_sum,
  output logic [STAMP_W-1:0]    first_stamp,
  output logic [STAMP_W-1:0]    last_stamp
);

  localparam int MEAN_W = GAP_W + MEAN_FRAC_BITS;
  localparam int PROD_W = 2 * MEAN_W;
  localparam int EXT_W  = PROD_W + SUM_FRAC;
  localparam int SCALE  = 2 * MEAN_FRAC_BITS;

  esi_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] total;
  logic [STAMP_W-1:0]     first_time;
  logic [STAMP_W-1:0]     prev_time;
  logic [GAP_W-1:0]       gap_min;
  logic [GAP_W-1:0]       gap_max;
  logic [MEAN_W-1:0]      mean;
  logic [SUM_W-1:0]       dev_sum;

  logic [MEAN_W-1:0] x;
  logic [MEAN_W-1:0] d;
  logic [MEAN_W-1:0] e;
  logic              xge;

  logic                   accept;
  logic                   load_out;
  logic [GAP_W-1:0]       gap;
  logic [MEAN_W-1:0]      x_new;
  logic [COUNT_WIDTH-1:0] total_inc;
  logic                   few_events;

  esi_unit_ctl_t       ctl;
  esi_unit_sts_t       sts;
  logic [MEAN_W-1:0]   quot;
  logic [PROD_W-1:0]   prod;

  logic [EXT_W-1:0]  prod_sh;
  logic [SUM_W-1:0]  add_term;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_next;
  logic [SEEN_W-1:0] seen_val;
  logic [MEAN_OUT_W-1:0] mean_val;

  esi_serial_unit #(
    .MEAN_W (MEAN_W),
    .CNT_W  (COUNT_WIDTH)
  ) u_unit (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .opa     (d),
    .opb     (e),
    .divisor (total),
    .sts     (sts),
    .quot    (quot),
    .prod    (prod)
  );

  always_comb begin
    gap        = now_us[GAP_W-1:0] - prev_time[GAP_W-1:0];
    x_new      = MEAN_W'(gap) << MEAN_FRAC_BITS;
    total_inc  = (&total) ? total : total + 1'b1;
    few_events = (total[COUNT_WIDTH-1:1] == '0);
    accept     = in_valid && in_ready;
  end

  // product is Q(2F); move to Q55.8 and saturate
  always_comb begin
    prod_sh  = {prod, {SUM_FRAC{1'b0}}} >> SCALE;
    add_term = (|prod_sh[EXT_W-1:SUM_W]) ? SUM_MAX : prod_sh[SUM_W-1:0];
    sum_wide = {1'b0, dev_sum} + {1'b0, add_term};
    sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_CLEAR || few_events) state_next = S_DONE;
          else                                  state_next = S_DIV;
        end
      end
      S_DIV:  state_next = S_DIVW;
      S_DIVW: if (sts.done) state_next = S_MEAN;
      S_MEAN: state_next = S_ERR;
      S_ERR:  state_next = S_MUL;
      S_MUL:  state_next = S_MULW;
      S_MULW: if (sts.done) state_next = S_SUM;
      S_SUM:  state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctl.start = 1'b0;
    ctl.op    = OP_DIV;
    load_out  = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_DIV:  ctl.start = 1'b1;
      S_MUL: begin
        ctl.start = 1'b1;
        ctl.op    = OP_MUL;
      end
      S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      first_time <= '0;
      prev_time  <= '0;
      gap_min    <= '0;
      gap_max    <= '0;
      mean       <= '0;
      dev_sum    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (func == FUNC_CLEAR) begin
          total      <= '0;
          first_time <= '0;
          prev_time  <= '0;
          gap_min    <= '0;
          gap_max    <= '0;
          mean       <= '0;
          dev_sum    <= '0;
        end else begin
          prev_time <= now_us;
          if (total == '0) begin
            first_time <= now_us;
            total      <= total_inc;
          end else if (few_events) begin
            gap_min <= gap;
            gap_max <= gap;
            mean    <= x_new;
            dev_sum <= '0;
            total   <= total_inc;
          end else begin
            if (gap < gap_min) gap_min <= gap;
            if (gap > gap_max) gap_max <= gap;
          end
        end
      end
      if (state == S_MEAN) mean <= xge ? mean + quot : mean - quot;
      if (state == S_SUM) begin
        dev_sum <= sum_next;
        total   <= total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x   <= x_new;
      xge <= (x_new >= mean);
      d   <= (x_new >= mean) ? x_new - mean : mean - x_new;
    end
    if (state == S_ERR) e <= xge ? x - mean : mean - x;
  end

  generate
    if (COUNT_WIDTH > SEEN_W) begin : g_seen_sat
      assign seen_val = (|total[COUNT_WIDTH-1:SEEN_W]) ? {SEEN_W{1'b1}} : total[SEEN_W-1:0];
    end else begin : g_seen_ext
      assign seen_val = SEEN_W'(total);
    end
    if (MEAN_W > MEAN_OUT_W) begin : g_mean_cut
      assign mean_val = mean[MEAN_OUT_W-1:0];
    end else begin : g_mean_ext
      assign mean_val = MEAN_OUT_W'(mean);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      events_seen  <= seen_val;
      shortest_gap <= gap_min;
      longest_gap  <= gap_max;
      mean_gap     <= mean_val;
      spread_sum   <= dev_sum;
      first_stamp  <= first_time;
      last_stamp   <= prev_time;
    end
  end

`ifndef SYNTH
  a_unit_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.busy |-> (state == S_DIVW || state == S_MULW))
    else $error("serial unit busy outside a wait state");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && events_seen >= SEEN_W'(2)) |-> (shortest_gap <= longest_gap))
    else $error("shortest gap above longest gap");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && events_seen == '0) |->
      (mean_gap == '0 && spread_sum == '0 && first_stamp == '0 && last_stamp == '0))
    else $error("statistics not zero with no events");

  a_single_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && events_seen == SEEN_W'(1)) |->
      (first_stamp == last_stamp && spread_sum == '0 && mean_gap == '0))
    else $error("single event result inconsistent");
`endif

endmodule
